@@ hdl/brf_pkg.sv @@
// Package for the byte ring FIFO: payload structs, operation, status,
// policy and register index codes, and the ring geometry constants.
// No dependencies.
`default_nettype none

package brf_pkg;

    // Ring geometry.
    localparam int MAX_DEPTH = 256;
    localparam int IDX_W     = $clog2(MAX_DEPTH);
    localparam int SIZE_W    = IDX_W + 1;

    // Configuration port.
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_ADDR_W-1:0] CFG_FULL_POLICY = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RING_SIZE   = 2'd1;

    // Operation codes.
    localparam logic [1:0] KIND_PUSH  = 2'd0;
    localparam logic [1:0] KIND_POP   = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // Policies for a push into a full ring.
    localparam logic [1:0] POL_REFUSE    = 2'd0;
    localparam logic [1:0] POL_DROP_NEW  = 2'd1;
    localparam logic [1:0] POL_BUSY      = 2'd2;
    localparam logic [1:0] POL_OVERWRITE = 2'd3;

    // Result status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EMPTY     = 3'd1;
    localparam logic [2:0] ST_REFUSED   = 3'd2;
    localparam logic [2:0] ST_DROPPED   = 3'd3;
    localparam logic [2:0] ST_BUSY      = 3'd4;
    localparam logic [2:0] ST_OVERWROTE = 3'd5;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] push_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_byte;
        logic [2:0] status;
        logic       overflow_seen;
        logic [7:0] free_entries;
    } out_item_t;

endpackage

`default_nettype wire

@@ hdl/byte_ring_fifo_overflow_policy_top.sv @@
// Byte ring FIFO with a selectable policy for pushes into a full ring.
// Depends on brf_pkg for payload types, codes and geometry constants.
`default_nettype none

// Each transfer on the input channel is a push, a pop or a clear and yields
// exactly one result transfer. One item is taken every cycle: the item is
// decoded against the ring pointers in the cycle it is accepted and its
// result lands in the output register on the same edge, so the input
// stalls only while a result waits on m_ready. The byte store is a 256 x 8
// memory with one write and one registered read port; the read port always
// holds the byte at the head of the ring, with a bypass when a push writes
// the slot that becomes the head. Writing ring_size empties the ring and
// clears overflow; values below 2 act as 2 and values above 256 act as 256.
// Configuration writes are meant to happen only while no result is
// outstanding.
module byte_ring_fifo_overflow_policy_top (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           s_valid,
    output logic                          s_ready,
    input  brf_pkg::in_item_t             s_data,
    output logic                          m_valid,
    input  wire                           m_ready,
    output brf_pkg::out_item_t            m_data,
    input  wire                           cfg_we,
    input  wire [brf_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire [brf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import brf_pkg::*;

    logic [1:0]        policy_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [SIZE_W-1:0] size_next;
    logic [IDX_W-1:0]  wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              ovf_reg, ovf_next;
    logic              m_valid_reg;
    out_item_t         m_data_reg, m_data_next;

    logic [7:0]        mem [MAX_DEPTH];
    logic [7:0]        head_reg;

    logic              accept;
    logic [IDX_W-1:0]  wr_adv, rd_adv;
    logic              full, empty;
    logic              mem_we;
    logic [IDX_W-1:0]  wr_step, rd_step;
    logic [SIZE_W-1:0] used;
    logic [SIZE_W-1:0] free_full;
    logic [7:0]        rb;
    logic [2:0]        status;
    logic              size_wr;

    // Advance a ring index, wrapping at the size in use.
    function automatic logic [IDX_W-1:0] adv_idx(input logic [IDX_W-1:0] idx,
                                                 input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] inc;
        inc = {1'b0, idx} + 1'b1;
        return (inc == size) ? '0 : inc[IDX_W-1:0];
    endfunction

    assign accept  = s_valid && s_ready;
    assign s_ready = !m_valid_reg || m_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign size_wr = cfg_we && (cfg_addr == CFG_RING_SIZE);

    // Clamp a written ring size into the supported range.
    always_comb begin
        if (cfg_wdata < SIZE_W'(2)) begin
            size_next = SIZE_W'(2);
        end else if (cfg_wdata > SIZE_W'(MAX_DEPTH)) begin
            size_next = SIZE_W'(MAX_DEPTH);
        end else begin
            size_next = cfg_wdata[SIZE_W-1:0];
        end
    end

    // Decode one item against the current pointers.
    always_comb begin
        wr_adv  = adv_idx(wr_idx_reg, size_reg);
        rd_adv  = adv_idx(rd_idx_reg, size_reg);
        full    = (wr_adv == rd_idx_reg);
        empty   = (wr_idx_reg == rd_idx_reg);
        wr_step = wr_idx_reg;
        rd_step = rd_idx_reg;
        ovf_next = ovf_reg;
        mem_we  = 1'b0;
        rb      = 8'd0;
        status  = ST_OK;
        case (s_data.kind)
            KIND_PUSH: begin
                if (!full) begin
                    mem_we  = 1'b1;
                    wr_step = wr_adv;
                end else begin
                    unique case (policy_reg)
                        POL_REFUSE: status = ST_REFUSED;
                        POL_DROP_NEW: begin
                            ovf_next = 1'b1;
                            status   = ST_DROPPED;
                        end
                        POL_BUSY: status = ST_BUSY;
                        default: begin
                            // Discard the oldest byte and store the new one.
                            rd_step  = rd_adv;
                            mem_we   = 1'b1;
                            wr_step  = wr_adv;
                            ovf_next = 1'b1;
                            status   = ST_OVERWROTE;
                        end
                    endcase
                end
            end
            KIND_POP: begin
                if (!empty) begin
                    rb      = head_reg;
                    rd_step = rd_adv;
                end else begin
                    status = ST_EMPTY;
                end
                ovf_next = 1'b0;
            end
            KIND_CLEAR: wr_step = rd_idx_reg;
            default: ;
        endcase
        mem_we = mem_we && accept;

        // Free slots after the item: size - 1 - used.
        if (wr_step >= rd_step) begin
            used = {1'b0, wr_step} - {1'b0, rd_step};
        end else begin
            used = {1'b0, wr_step} + size_reg - {1'b0, rd_step};
        end
        free_full = size_reg - SIZE_W'(1) - used;

        m_data_next.read_byte     = rb;
        m_data_next.status        = status;
        m_data_next.overflow_seen = ovf_next;
        m_data_next.free_entries  = free_full[7:0];
    end

    // Next pointer values, including the reset of the ring on a size write.
    always_comb begin
        if (size_wr) begin
            wr_idx_next = '0;
            rd_idx_next = '0;
        end else if (accept) begin
            wr_idx_next = wr_step;
            rd_idx_next = rd_step;
        end else begin
            wr_idx_next = wr_idx_reg;
            rd_idx_next = rd_idx_reg;
        end
    end

    // Control state, configuration and the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg  <= POL_REFUSE;
            size_reg    <= SIZE_W'(MAX_DEPTH);
            wr_idx_reg  <= '0;
            rd_idx_reg  <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            if (size_wr) begin
                size_reg <= size_next;
                ovf_reg  <= 1'b0;
            end else if (accept) begin
                ovf_reg <= ovf_next;
            end
            if (cfg_we && (cfg_addr == CFG_FULL_POLICY)) begin
                policy_reg <= cfg_wdata[1:0];
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

    // Byte store; the registered read always tracks the byte at the head,
    // taking the pushed byte directly when it lands on the new head slot.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_idx_reg] <= s_data.push_byte;
        end
        if (mem_we && (wr_idx_reg == rd_idx_next)) begin
            head_reg <= s_data.push_byte;
        end else begin
            head_reg <= mem[rd_idx_next];
        end
    end

endmodule

`default_nettype wire
